// ===== sv/cmr_pkg.sv =====
// Package for the cluster merge and relabel block: word types, request codes,
// register indexes and size constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cmr_pkg;

  localparam int MAX_CLUSTERS_DEF = 64;
  localparam int LABEL_W          = 7;
  localparam int INDEX_W          = 6;
  localparam int SCORE_W          = 16;

  localparam logic [1:0] REQ_SCORE   = 2'd0;
  localparam logic [1:0] REQ_RESOLVE = 2'd1;
  localparam logic [1:0] REQ_LABEL   = 2'd2;
  localparam logic [1:0] REQ_SPARE   = 2'd3;

  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_LABEL   = 1'b1;

  localparam logic [SCORE_W-1:0] THRESH_RESET = 16'd29491;
  localparam logic [LABEL_W-1:0] COUNT_RESET  = 7'd64;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [INDEX_W-1:0]        row_index;
    logic [INDEX_W-1:0]        col_index;
    logic signed [SCORE_W-1:0] score;
    logic [LABEL_W-1:0]        old_label;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic [LABEL_W-1:0] merged_label;
    logic [LABEL_W-1:0] clusters_used;
    logic               label_error;
  } out_word_t;

  // per-cycle commands from the sequencer to every cell
  typedef struct packed {
    logic clr;      // drop all merge bits
    logic init;     // load root candidate with own index, zero the label
    logic set_en;   // score entry sets one merge bit
    logic clos_en;  // closure step: OR in the pivot row
    logic root_en;  // root step: take a smaller root from the pivot
    logic num_en;   // numbering step: capture the dense label
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/cmr_cell.sv =====
// One cell of the cluster chain: holds the merge row, root candidate and final
// label of one cluster. Depends on cmr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmr_cell import cmr_pkg::*; #(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int IDX          = 0,
  parameter int IDX_W        = $clog2(MAX_CLUSTERS),
  parameter int CNT_W        = $clog2(MAX_CLUSTERS + 1)
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  cell_ctl_t              ctl,
  input  wire [IDX_W-1:0]        set_row,
  input  wire [IDX_W-1:0]        set_col,
  input  wire [IDX_W-1:0]        step,
  input  wire [CNT_W-1:0]        k_act,
  input  wire [MAX_CLUSTERS-1:0] piv_row,
  input  wire [IDX_W-1:0]        root_val,
  input  wire [LABEL_W-1:0]      num_val,
  output logic [MAX_CLUSTERS-1:0] row_q,
  output logic [IDX_W-1:0]        cand_q,
  output logic [LABEL_W-1:0]      flab_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [MAX_CLUSTERS-1:0] row_r;
  logic [IDX_W-1:0]        cand_r;
  logic [LABEL_W-1:0]      flab_r;
  logic                    active;

  assign active = CNT_W'(IDX) < k_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (ctl.clr) begin
      row_r <= '0;
    end else if (ctl.set_en && set_row == MY_IDX) begin
      row_r[set_col] <= 1'b1;
    end else if (ctl.clos_en && active && row_r[step]) begin
      row_r <= row_r | piv_row;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      cand_r <= MY_IDX;
      flab_r <= '0;
    end else begin
      if (ctl.root_en && active && MY_IDX > step && row_r[step] && root_val < cand_r) begin
        cand_r <= root_val;
      end
      if (ctl.num_en && active && cand_r == step) begin
        flab_r <= num_val;
      end
    end
  end

  assign row_q  = row_r;
  assign cand_q = cand_r;
  assign flab_q = flab_r;

endmodule
`default_nettype wire

// ===== sv/cluster_merge_relabel.sv =====
// Top level of the cluster merge and relabel block: APB registers, sequencer,
// output register and the chain of cmr_cell. Depends on cmr_pkg, cmr_cell.
//
//  port group   direction  word        handshake
//  in_*         in         in_word_t   in_valid / in_stall
//  out_*        out        out_word_t  out_valid / out_stall
//  psel ...     in/out     32-bit APB  pready tied high
//
// A resolve holds the input from its accept cycle through K closure steps, K root
// steps and K numbering steps over the cell chain (K = active cluster count), one
// pivot cluster per cycle; the summary word enters the output register at the
// last numbering step. A request that produces a word stalls while the output
// register holds a stalled word.
// Reset clears all merge bits, the registers and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module cluster_merge_relabel import cmr_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  wire        out_stall,
  output out_word_t  out_data,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam int MAX_CLUSTERS = MAX_CLUSTERS_DEF;
  localparam int IDX_W = $clog2(MAX_CLUSTERS);
  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int LW    = (CNT_W > LABEL_W) ? CNT_W : LABEL_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CLOS = 4'b0010,
    S_ROOT = 4'b0100,
    S_NUM  = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [SCORE_W-1:0] thresh_r;
  logic [LABEL_W-1:0]       count_r;
  logic [IDX_W-1:0]         step_r, step_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [LABEL_W-1:0]       used_r, used_nxt;
  logic [MAX_CLUSTERS-1:0]  live_r, live_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_r, out_nxt;

  logic [CNT_W-1:0]         k_act;
  logic [LW-1:0]            cc_w;
  logic                     in_acc, out_acc, cfg_wr, last_step;
  cell_ctl_t                ctl;
  logic [MAX_CLUSTERS-1:0]  row_q [MAX_CLUSTERS];
  logic [IDX_W-1:0]         cand_q [MAX_CLUSTERS];
  logic [LABEL_W-1:0]       flab_q [MAX_CLUSTERS];
  logic [IDX_W-1:0]         root_val;
  logic [LABEL_W-1:0]       num_val;
  logic [LW-1:0]            lab_w, lab_m1;
  logic [LABEL_W-1:0]       lab_read;
  logic                     lab_bad;

  // active cluster count, clamped to 1..MAX_CLUSTERS
  assign cc_w = LW'(count_r);
  always_comb begin
    if (cc_w == '0) begin
      k_act = CNT_W'(1);
    end else if (cc_w > LW'(MAX_CLUSTERS)) begin
      k_act = CNT_W'(MAX_CLUSTERS);
    end else begin
      k_act = cc_w[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_THRESH: prdata = {{(32-SCORE_W){1'b0}}, thresh_r};
      REG_COUNT:  prdata = {{(32-LABEL_W){1'b0}}, count_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      count_r  <= COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_THRESH: thresh_r <= pwdata[SCORE_W-1:0];
        REG_COUNT:  count_r  <= pwdata[LABEL_W-1:0];
        default:    ;
      endcase
    end
  end

  // hold every word while a resolve runs, and any word but a score entry while the output slot holds a stalled word
  assign in_stall = (state_r != S_IDLE) ||
                    (out_valid_r && out_stall && in_data.req_type != REQ_SCORE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign last_step = CNT_W'(step_r) == k_act - CNT_W'(1);

  assign root_val = cand_q[step_r];
  assign num_val  = LABEL_W'(n_r + CNT_W'(1));

  // label lookup
  assign lab_w    = LW'(in_data.old_label);
  assign lab_m1   = lab_w - LW'(1);
  assign lab_bad  = (lab_w == '0) || (lab_w > LW'(k_act));
  assign lab_read = flab_q[lab_m1[IDX_W-1:0]];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    n_nxt         = n_r;
    used_nxt      = used_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_nxt       = out_r;
    ctl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.req_type)
            REQ_SCORE: begin
              ctl.set_en = (32'(in_data.row_index) < 32'(MAX_CLUSTERS)) &&
                           (32'(in_data.col_index) < 32'(MAX_CLUSTERS)) &&
                           (in_data.score > thresh_r);
            end
            REQ_RESOLVE: begin
              ctl.init  = 1'b1;
              live_nxt  = '0;
              step_nxt  = '0;
              n_nxt     = '0;
              state_nxt = S_CLOS;
            end
            REQ_LABEL: begin
              out_valid_nxt         = 1'b1;
              out_nxt.result_kind   = KIND_LABEL;
              out_nxt.clusters_used = used_r;
              if (lab_bad || lab_read == '0) begin
                out_nxt.merged_label = '0;
                out_nxt.label_error  = 1'b1;
              end else begin
                out_nxt.merged_label = lab_read;
                out_nxt.label_error  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLOS: begin
        ctl.clos_en = 1'b1;
        step_nxt    = last_step ? '0 : step_r + IDX_W'(1);
        if (last_step) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        ctl.root_en        = 1'b1;
        live_nxt[root_val] = 1'b1;
        step_nxt           = last_step ? '0 : step_r + IDX_W'(1);
        if (last_step) state_nxt = S_NUM;
      end
      S_NUM: begin
        ctl.num_en = 1'b1;
        if (live_r[step_r]) n_nxt = n_r + CNT_W'(1);
        step_nxt = step_r + IDX_W'(1);
        if (last_step) begin
          ctl.clr               = 1'b1;
          used_nxt              = LABEL_W'(n_nxt);
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = KIND_SUMMARY;
          out_nxt.merged_label  = '0;
          out_nxt.clusters_used = LABEL_W'(n_nxt);
          out_nxt.label_error   = 1'b0;
          step_nxt              = '0;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      n_r         <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      n_r         <= n_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    live_r <= live_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  for (genvar gi = 0; gi < MAX_CLUSTERS; gi++) begin : g_cell
    cmr_cell #(
      .MAX_CLUSTERS(MAX_CLUSTERS),
      .IDX         (gi),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .set_row (in_data.row_index[IDX_W-1:0]),
      .set_col (in_data.col_index[IDX_W-1:0]),
      .step    (step_r),
      .k_act   (k_act),
      .piv_row (row_q[step_r]),
      .root_val(root_val),
      .num_val (num_val),
      .row_q   (row_q[gi]),
      .cand_q  (cand_q[gi]),
      .flab_q  (flab_q[gi])
    );
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken during resolve");

  a_resolve_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.req_type == REQ_RESOLVE) |=> (state_r == S_CLOS))
    else $error("resolve did not start closure");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.label_error) |-> (out_r.merged_label == '0))
    else $error("flagged label carries a value");

  a_state_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state corrupt");

endmodule
`default_nettype wire

// ===== tb/sv/cmr_checker.sv =====
// Checker for the cluster merge and relabel block: watches the input and
// output channels, predicts result words and compares them. Depends on cmr_pkg.
`timescale 1ns / 1ps
module cmr_checker import cmr_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  input  wire       in_stall,
  input  in_word_t  in_data,
  input  wire       out_valid,
  input  wire       out_stall,
  input  out_word_t out_data,
  input  wire       cfg_wr,
  input  wire [2:0] cfg_addr,
  input  wire [31:0] cfg_wdata,
  output int        fail_count,
  output int        pending
);

  logic signed [15:0] thresh;
  logic [6:0]         count_reg;
  logic [63:0]        merges [64];
  logic [5:0]         roots [64];
  logic [6:0]         labels [64];
  logic [6:0]         survivors;
  out_word_t          expected_words[$];

  function automatic int active_k();
    if (count_reg < 1) return 1;
    if (count_reg > 64) return 64;
    return count_reg;
  endfunction

  // fold the merge relation, pick roots, number survivors, then clear
  function automatic logic [6:0] resolve_clusters();
    int k;
    logic live [64];
    logic [6:0] num [64];
    logic [6:0] n;
    logic [5:0] r;
    k = active_k();
    n = 0;
    for (int j = 0; j < k; j++)
      for (int i = 0; i < k; i++)
        if (merges[i][j]) merges[i] = merges[i] | merges[j];
    for (int i = 0; i < 64; i++) begin
      r = i[5:0];
      if (i < k)
        for (int j = 0; j < i; j++)
          if (merges[i][j] && roots[j] < r) r = roots[j];
      roots[i] = r;
    end
    for (int i = 0; i < 64; i++) live[i] = 0;
    for (int i = 0; i < k; i++) live[roots[i]] = 1;
    for (int i = 0; i < 64; i++) begin
      if (live[i]) n = n + 1;
      num[i] = live[i] ? n : 7'd0;
    end
    for (int i = 0; i < 64; i++) labels[i] = (i < k) ? num[roots[i]] : 7'd0;
    survivors = n;
    for (int i = 0; i < 64; i++) merges[i] = '0;
    return n;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    out_word_t got;
    int k;
    if (!rst_n) begin
      thresh <= THRESH_RESET;
      count_reg <= COUNT_RESET;
      for (int i = 0; i < 64; i++) begin
        merges[i] = '0;
        roots[i] = i[5:0];
        labels[i] = '0;
      end
      survivors = 0;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr) begin
        if (cfg_addr[2] == REG_THRESH) thresh <= cfg_wdata[15:0];
        else count_reg <= cfg_wdata[6:0];
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (got !== e) begin
            if (fail_count < 10)
              $display("mismatch: exp kind %0d lab %0d used %0d err %0d, got %0d %0d %0d %0d",
                       e.result_kind, e.merged_label, e.clusters_used, e.label_error,
                       got.result_kind, got.merged_label, got.clusters_used,
                       got.label_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.req_type)
          REQ_SCORE: if (in_data.score > thresh)
            merges[in_data.row_index][in_data.col_index] = 1'b1;
          REQ_RESOLVE: begin
            e.result_kind = KIND_SUMMARY;
            e.merged_label = 0;
            e.clusters_used = resolve_clusters();
            e.label_error = 0;
            expected_words.push_back(e);
          end
          REQ_LABEL: begin
            k = active_k();
            e.result_kind = KIND_LABEL;
            e.merged_label = 0;
            e.clusters_used = survivors;
            e.label_error = (in_data.old_label == 0 || in_data.old_label > k);
            if (!e.label_error) begin
              e.merged_label = labels[in_data.old_label - 1];
              if (e.merged_label == 0) e.label_error = 1;
            end
            expected_words.push_back(e);
          end
          default: ;
        endcase
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== tb/sv/tb_cluster_merge_relabel.sv =====
// Top of the cluster merge and relabel testbench: clock, reset, APB writes,
// request stimulus and verdict. Depends on cmr_pkg, cmr_checker and the block.
`timescale 1ns / 1ps
module tb_cluster_merge_relabel;
  import cmr_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int cycles = 0;
  int cur_k = 64;
  bit did_resolve = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  cluster_merge_relabel u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cmr_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr(psel && penable && pwrite && pready), .cfg_addr(paddr),
    .cfg_wdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall pattern: phases of none, light and heavy stalling
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_COUNT) cur_k = (value[6:0] < 1) ? 1 : (value[6:0] > 64 ? 64 : value[6:0]);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (3 * 64 + 10) @(posedge clk);
  endtask

  // hold the word until accepted; valid stays high for the caller to lower
  task automatic send_word(input in_word_t w);
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.req_type == REQ_RESOLVE) did_resolve = 1;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic in_word_t make_req(input logic [1:0] rt, input int r, input int c,
                                        input int s, input int lab);
    in_word_t w;
    w.req_type = rt;
    w.row_index = r[5:0];
    w.col_index = c[5:0];
    w.score = s[15:0];
    w.old_label = lab[6:0];
    return w;
  endfunction

  // label requests only after a resolve, since labels are unwritten until then
  function automatic in_word_t rand_req();
    int sel;
    int lo;
    sel = $urandom_range(0, 99);
    lo = cur_k - 1;
    if (sel < 70)
      return make_req(REQ_SCORE, $urandom_range(0, lo), $urandom_range(0, lo),
                      $urandom(), 0);
    if (sel < 75)
      return make_req(REQ_SCORE, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom(), $urandom());
    if (sel < 77) return make_req(REQ_SPARE, $urandom(), $urandom(), $urandom(), $urandom());
    if (sel < 82 || !did_resolve) return make_req(REQ_RESOLVE, 0, 0, 0, 0);
    if (sel < 97) return make_req(REQ_LABEL, $urandom(), $urandom(), $urandom(),
                                  $urandom_range(0, cur_k));
    return make_req(REQ_LABEL, 0, 0, 0, $urandom_range(0, 127));
  endfunction

  task automatic random_phase(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      send_word(rand_req());
      sent++;
      idle_gap();
    end
    in_valid <= 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    // directed: chain merge, extremes, unused code, flagged labels
    write_reg(REG_THRESH, 32'h0000_0000);
    write_reg(REG_COUNT, 32'd8);
    send_word(make_req(REQ_SCORE, 1, 0, 32767, 0));
    send_word(make_req(REQ_SCORE, 3, 1, 1, 0));
    send_word(make_req(REQ_SCORE, 5, 4, 0, 0));
    send_word(make_req(REQ_SCORE, 6, 2, -32768, 0));
    send_word(make_req(REQ_SCORE, 63, 63, 32767, 0));
    send_word(make_req(REQ_SCORE, 7, 6, 32767, 0));
    send_word(make_req(REQ_SCORE, 2, 7, 32767, 0));
    send_word(make_req(REQ_SPARE, 63, 63, -1, 127));
    send_word(make_req(REQ_RESOLVE, 0, 0, 0, 0));
    send_word(make_req(REQ_LABEL, 0, 0, 0, 0));
    send_word(make_req(REQ_LABEL, 0, 0, 0, 1));
    send_word(make_req(REQ_LABEL, 0, 0, 0, 4));
    send_word(make_req(REQ_LABEL, 0, 0, 0, 8));
    send_word(make_req(REQ_LABEL, 0, 0, 0, 9));
    send_word(make_req(REQ_LABEL, 63, 63, -1, 127));
    send_word(make_req(REQ_RESOLVE, 0, 0, 0, 0));
    in_valid <= 0;
    wait_idle();
    write_reg(REG_COUNT, 32'd0);
    write_reg(REG_THRESH, 32'h0000_7fff);
    send_word(make_req(REQ_SCORE, 0, 0, 32767, 0));
    send_word(make_req(REQ_RESOLVE, 0, 0, 0, 0));
    send_word(make_req(REQ_LABEL, 0, 0, 0, 1));
    send_word(make_req(REQ_LABEL, 0, 0, 0, 2));
    in_valid <= 0;
    wait_idle();
    // random phases over several settings
    write_reg(REG_THRESH, 32'h0000_8000);
    write_reg(REG_COUNT, 32'd64);
    random_phase(200);
    wait_idle();
    write_reg(REG_THRESH, 32'h0000_6000);
    write_reg(REG_COUNT, 32'd6);
    random_phase(200);
    wait_idle();
    write_reg(REG_THRESH, 32'h0000_0000);
    write_reg(REG_COUNT, 32'd100);
    random_phase(200);
    wait_idle();
    write_reg(REG_THRESH, 32'h0000_c000);
    write_reg(REG_COUNT, 32'd1);
    random_phase(50);
    wait_idle();
    write_reg(REG_COUNT, 32'd16);
    random_phase(150);
    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cmr_pkg.sv
sv/cmr_cell.sv
sv/cluster_merge_relabel.sv
tb/sv/cmr_checker.sv
tb/sv/tb_cluster_merge_relabel.sv
